// ===== src/uea_pkg.sv =====
// uea_pkg: shared types and constants for the ultrasonic echo averager
// no dependencies; imported by the controller, the datapath and the top level
`default_nettype none

package uea_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // register widths
    localparam int SC_W   = 8;
    localparam int TO_W   = 16;
    localparam int GAP_W  = 17;
    localparam int TRIG_W = 8;

    // measurement counters
    localparam int TICK_W = 17;
    localparam int IDX_W  = 8;

    // result fields
    localparam int AVG_W = 16;
    localparam int VS_W  = 8;

    // register reset values
    localparam logic [SC_W-1:0]   SC_RST   = 8'd5;
    localparam logic [TO_W-1:0]   TO_RST   = 16'd30000;
    localparam logic [GAP_W-1:0]  GAP_RST  = 17'd50000;
    localparam logic [TRIG_W-1:0] THIGH_RST = 8'd10;
    localparam logic [TRIG_W-1:0] TLOW_RST  = 8'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_COUNT = 3'd0,
        CFG_TIMEOUT_US   = 3'd1,
        CFG_GAP_US       = 3'd2,
        CFG_TRIG_HIGH_US = 3'd3,
        CFG_TRIG_LOW_US  = 3'd4
    } t_cfg_idx;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the accepted item
        logic exec;      // apply the item to the measurement state
        logic div_init;  // load the divider
        logic div_step;  // one quotient bit
        logic load_out;  // write the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_need;  // run finished with at least one good sample
        logic div_last;  // this step produces the last quotient bit
        logic out_free;  // result register can take a new item
    } t_stat;

endpackage

`default_nettype wire

// ===== src/uea_in_if.sv =====
// uea_in_if: input channel of the echo averager (valid/ready plus item payload)
// no dependencies
`default_nettype none

interface uea_in_if;
    logic valid;
    logic ready;
    logic kind;
    logic echo;

    modport source (output valid, output kind, output echo, input ready);
    modport sink   (input valid, input kind, input echo, output ready);
endinterface

`default_nettype wire

// ===== src/uea_res_if.sv =====
// uea_res_if: result channel of the echo averager (valid/ready plus result payload)
// no dependencies
`default_nettype none

interface uea_res_if;
    logic        valid;
    logic        ready;
    logic        trigger;
    logic        busy_res;
    logic        done_res;
    logic        status;
    logic [15:0] average_us;
    logic [7:0]  valid_samples;

    modport source (output valid, output trigger, output busy_res, output done_res,
                    output status, output average_us, output valid_samples,
                    input ready);
    modport sink   (input valid, input trigger, input busy_res, input done_res,
                    input status, input average_us, input valid_samples,
                    output ready);
endinterface

`default_nettype wire

// ===== src/ultrasonic_echo_averager_top.sv =====
// ultrasonic_echo_averager_top: hc-sr04 style echo timer that averages a run of samples
// depends on uea_pkg, uea_in_if, uea_res_if, uea_ctrl and uea_dp
`default_nettype none

//  channel   dir  handshake     payload
//  i_in      in   valid/ready   kind (0 tick, 1 start), echo
//  o_res     out  valid/ready   trigger, busy_res, done_res, status, average_us,
//                               valid_samples
//  i_cfg_*   in   write enable  i_cfg_idx selects the register, i_cfg_data its value
//
//  an item passes through accept, execute, decide and emit in turn; its result is written
//  to the result register in the emit step; an item that ends a run with at least one good
//  sample adds a divide step between decide and emit for the one-bit-a-cycle divider
//  a new item is accepted once the previous one has reached the result register,
//  even while that result still waits; the result register stalls only the emit step
//  synchronous active-low reset restores the register defaults and the idle phase

module ultrasonic_echo_averager_top
    import uea_pkg::*;
#(
    parameter int DURATION_BITS = 16,
    parameter int COUNT_BITS    = 8
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    uea_in_if.sink               i_in,
    uea_res_if.source            o_res,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data
);

    // command and status between sequencer and datapath
    t_cmd  w_cmd;
    t_stat w_st;
    logic  w_in_ready;

    assign i_in.ready = w_in_ready;

    // sequencer: capture, execute, divide when a run ends, emit
    uea_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    // datapath: phase counters, running sum, divider and result register
    uea_dp #(
        .DURATION_BITS (DURATION_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_st       (w_st),
        .i_kind     (i_in.kind),
        .i_echo     (i_in.echo),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_res      (o_res)
    );

endmodule

`default_nettype wire

// ===== src/uea_ctrl.sv =====
// uea_ctrl: sequencer for one item (capture, execute, optional divide, emit)
// depends on uea_pkg
`default_nettype none

module uea_ctrl
    import uea_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_st,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DECIDE,
        S_DIV,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_EXEC;
            S_EXEC:   n_state = S_DECIDE;
            S_DECIDE: n_state = i_st.div_need ? S_DIV : S_EMIT;
            S_DIV:    if (i_st.div_last) n_state = S_EMIT;
            S_EMIT:   if (i_st.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_cmd.capture    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec       = (r_state == S_EXEC);
    assign o_cmd.div_init   = (r_state == S_DECIDE);
    assign o_cmd.div_step   = (r_state == S_DIV);
    assign o_cmd.load_out   = (r_state == S_EMIT) && i_st.out_free;

endmodule

`default_nettype wire

// ===== src/uea_dp.sv =====
// uea_dp: measurement state, configuration registers, serial divider, result register
// depends on uea_pkg and uea_res_if
`default_nettype none

module uea_dp
    import uea_pkg::*;
#(
    parameter int DURATION_BITS = 16,
    parameter int COUNT_BITS    = 8
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_st,
    input  wire                   i_kind,
    input  wire                   i_echo,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    uea_res_if.source             o_res
);

    localparam int SUM_W = DURATION_BITS + COUNT_BITS;
    localparam int DCW   = $clog2(SUM_W);
    localparam int TEXT_W = TICK_W + DURATION_BITS;
    localparam int QEXT_W = SUM_W + AVG_W;
    localparam int GEXT_W = COUNT_BITS + VS_W;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TLOW,
        PH_THIGH,
        PH_RISE,
        PH_HIGH,
        PH_GAP
    } t_phase;

    // configuration
    logic [SC_W-1:0]   r_sc;
    logic [TO_W-1:0]   r_to;
    logic [GAP_W-1:0]  r_gap;
    logic [TRIG_W-1:0] r_thigh;
    logic [TRIG_W-1:0] r_tlow;

    // captured item
    logic r_kind;
    logic r_echo;

    // measurement state
    t_phase                 r_phase, n_phase;
    logic [TICK_W-1:0]      r_tick, n_tick;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [COUNT_BITS-1:0]  r_good, n_good;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic                   r_done, n_done;

    logic w_gap, w_end, w_start, w_finish;
    logic [TEXT_W-1:0]        w_tick_ext;
    logic [DURATION_BITS-1:0] w_dur;
    logic [SUM_W:0]           w_sum_add;

    // divider
    logic [COUNT_BITS-1:0] r_rem;
    logic [SUM_W-1:0]      r_quo;
    logic [DCW-1:0]        r_dcnt;
    logic [COUNT_BITS:0]   w_shift;
    logic                  w_qbit;
    logic [QEXT_W-1:0]     w_quo_ext;
    logic [AVG_W-1:0]      w_avg_sat;
    logic [GEXT_W-1:0]     w_good_ext;

    // result register
    logic             r_out_valid;
    logic             r_trigger;
    logic             r_busy;
    logic             r_done_o;
    logic             r_status;
    logic [AVG_W-1:0] r_avg;
    logic [VS_W-1:0]  r_vs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc    <= SC_RST;
            r_to    <= TO_RST;
            r_gap   <= GAP_RST;
            r_thigh <= THIGH_RST;
            r_tlow  <= TLOW_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SAMPLE_COUNT: r_sc    <= i_cfg_data[SC_W-1:0];
                CFG_TIMEOUT_US:   r_to    <= i_cfg_data[TO_W-1:0];
                CFG_GAP_US:       r_gap   <= i_cfg_data[GAP_W-1:0];
                CFG_TRIG_HIGH_US: r_thigh <= i_cfg_data[TRIG_W-1:0];
                CFG_TRIG_LOW_US:  r_tlow  <= i_cfg_data[TRIG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_echo <= i_echo;
        end
    end

    // saturated echo duration (ticks counted through the fall item) and saturating sum
    assign w_tick_ext = TEXT_W'(r_tick) + TEXT_W'(1);
    assign w_dur      = (|w_tick_ext[TEXT_W-1:DURATION_BITS]) ? '1
                                                              : w_tick_ext[DURATION_BITS-1:0];
    assign w_sum_add  = {1'b0, r_sum} + (SUM_W+1)'(w_dur);

    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_idx    = r_idx;
        n_good   = r_good;
        n_sum    = r_sum;
        n_done   = 1'b0;
        w_gap    = 1'b0;
        w_end    = 1'b0;
        w_start  = 1'b0;
        w_finish = 1'b0;

        if (r_kind) begin
            // start is ignored during a run
            if (r_phase == PH_IDLE) begin
                n_idx  = '0;
                n_good = '0;
                n_sum  = '0;
                if (r_sc == '0) w_finish = 1'b1;
                else            w_start  = 1'b1;
            end
        end else begin
            case (r_phase)
                PH_TLOW: begin
                    n_tick = r_tick + 1'b1;
                    if (n_tick >= TICK_W'(r_tlow)) begin
                        n_tick  = '0;
                        n_phase = PH_THIGH;
                    end
                end
                PH_THIGH: begin
                    n_tick = r_tick + 1'b1;
                    if (n_tick >= TICK_W'(r_thigh)) begin
                        n_tick  = '0;
                        n_phase = PH_RISE;
                    end
                end
                PH_RISE: begin
                    if (r_echo) begin
                        n_tick  = '0;
                        n_phase = PH_HIGH;
                    end else begin
                        n_tick = r_tick + 1'b1;
                        if (n_tick > TICK_W'(r_to)) w_gap = 1'b1;
                    end
                end
                PH_HIGH: begin
                    n_tick = r_tick + 1'b1;
                    if (!r_echo) begin
                        n_sum = w_sum_add[SUM_W] ? '1 : w_sum_add[SUM_W-1:0];
                        if (r_good != '1) n_good = r_good + 1'b1;
                        w_gap = 1'b1;
                    end else if (n_tick > TICK_W'(r_to)) begin
                        w_gap = 1'b1;
                    end
                end
                PH_GAP: begin
                    n_tick = r_tick + 1'b1;
                    if (n_tick >= r_gap) w_end = 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                end
            endcase
        end

        if (w_gap) begin
            n_tick  = '0;
            n_phase = PH_GAP;
            if (r_gap == '0) w_end = 1'b1;
        end
        if (w_end) begin
            n_idx = r_idx + 1'b1;
            if (n_idx >= IDX_W'(r_sc)) w_finish = 1'b1;
            else                       w_start  = 1'b1;
        end
        if (w_start) begin
            n_tick  = '0;
            n_phase = (r_tlow == '0) ? PH_THIGH : PH_TLOW;
        end
        if (w_finish) begin
            n_done  = 1'b1;
            n_phase = PH_IDLE;
            n_tick  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_idx   <= '0;
            r_good  <= '0;
            r_sum   <= '0;
            r_done  <= 1'b0;
        end else if (i_cmd.exec) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_idx   <= n_idx;
            r_good  <= n_good;
            r_sum   <= n_sum;
            r_done  <= n_done;
        end
    end

    // restoring division of the sum by the good count, one quotient bit a cycle
    assign w_shift = {r_rem, r_quo[SUM_W-1]};
    assign w_qbit  = (w_shift >= {1'b0, r_good});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem  <= '0;
            r_quo  <= r_sum;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= w_qbit ? COUNT_BITS'(w_shift - {1'b0, r_good})
                             : w_shift[COUNT_BITS-1:0];
            r_quo  <= {r_quo[SUM_W-2:0], w_qbit};
            r_dcnt <= r_dcnt + 1'b1;
        end
    end

    assign w_quo_ext  = QEXT_W'(r_quo);
    assign w_avg_sat  = (|w_quo_ext[QEXT_W-1:AVG_W]) ? '1 : w_quo_ext[AVG_W-1:0];
    assign w_good_ext = GEXT_W'(r_good);

    assign o_st.div_need = r_done && (r_good != '0);
    assign o_st.div_last = (r_dcnt == DCW'(SUM_W - 1));
    assign o_st.out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_trigger <= (r_phase == PH_THIGH);
            r_busy    <= (r_phase != PH_IDLE);
            r_done_o  <= r_done;
            r_status  <= r_done && (r_good == '0);
            r_avg     <= (r_done && (r_good != '0)) ? w_avg_sat : '0;
            r_vs      <= r_done ? w_good_ext[VS_W-1:0] : '0;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.trigger       = r_trigger;
    assign o_res.busy_res      = r_busy;
    assign o_res.done_res      = r_done_o;
    assign o_res.status        = r_status;
    assign o_res.average_us    = r_avg;
    assign o_res.valid_samples = r_vs;

`ifndef SYNTHESIS
    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> $stable(r_phase))
        else $error("measurement phase moved without an item");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || o_res.ready))
        else $error("result register overwritten while full");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_done_o) |-> (!r_busy && !r_trigger))
        else $error("finished run still reported busy");

    a_timeout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status) |-> (r_avg == '0 && r_done_o))
        else $error("timeout result carries an average");

    a_div_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_done && r_good != '0))
        else $error("divider running without a finished run");
`endif

endmodule

`default_nettype wire
